@@ rtl/rrts_pkg.sv @@
package rrts_pkg;

    localparam int MAX_CORES = 4;
    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int PTR_W     = SLOT_W + 1;
    localparam int CORE_W    = 2;
    localparam int CNT_W     = PTR_W;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_TASKS);

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_KILL = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_REFUSED  = 2'd3;

    localparam logic CFG_CORE_COUNT  = 1'b0;
    localparam logic CFG_APP_QUANTUM = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request
        logic scan_clr;  // restart slot scan
        logic scan_step; // compare one slot, advance
        logic do_add;
        logic do_tick;
        logic do_kill;
        logic emit;      // capture result beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic [1:0] req_type;
    } t_sts;

endpackage

@@ rtl/rrts_ctrl.sv @@
module rrts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_ov, n_ov;
    logic       out_free;

    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_stall     = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ov    = r_ov && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.do_add  = (i_sts.req_type == rrts_pkg::REQ_ADD);
                o_cmd.do_tick = (i_sts.req_type == rrts_pkg::REQ_TICK);
                o_cmd.do_kill = (i_sts.req_type == rrts_pkg::REQ_KILL);
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_ov       = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule

@@ rtl/rrts_dp.sv @@
module rrts_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrts_pkg::t_cmd        i_cmd,
    output rrts_pkg::t_sts        o_sts,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  logic [1:0]            i_req_type,
    input  logic [1:0]            i_core,
    input  logic                  i_is_driver,
    input  logic [31:0]           i_task_id,
    output logic [1:0]            o_status,
    output logic [31:0]           o_result_id,
    output logic [1:0]            o_result_core,
    output logic [4:0]            o_running_slot,
    output logic                  o_switched
);

    localparam int SW = rrts_pkg::SLOT_W;
    localparam int PW = rrts_pkg::PTR_W;
    localparam int NC = rrts_pkg::MAX_CORES;
    localparam int NT = rrts_pkg::MAX_TASKS;
    localparam logic [PW-1:0] NIL = rrts_pkg::NIL;

    logic [2:0]  r_core_count;
    logic [7:0]  r_app_quantum;

    logic [NT-1:0] r_valid;
    logic [31:0]   r_tid  [NT];
    logic [1:0]    r_score[NT];
    logic [PW-1:0] r_next [NT];
    logic [PW-1:0] r_prev [NT];
    logic [7:0]    r_qleft[NT];
    logic [7:0]    r_qtgt [NT];
    logic [PW-1:0] r_head [NC];
    logic [PW-1:0] r_tail [NC];
    logic [PW-1:0] r_run  [NC];
    logic [rrts_pkg::CNT_W-1:0] r_cnt[NC];
    logic [31:0]   r_next_id;

    logic [1:0]  r_rt, r_rc;
    logic        r_drv;
    logic [31:0] r_id;

    logic [PW-1:0] r_scan;
    logic [PW-1:0] r_free, r_hit;
    logic [1:0]    r_best;

    logic [1:0]  r_st, r_oc;
    logic [31:0] r_oid;
    logic [4:0]  r_orun;
    logic        r_osw;

    logic [1:0]  r_out_st, r_out_core;
    logic [31:0] r_out_id;
    logic [4:0]  r_out_run;
    logic        r_out_sw;

    logic [1:0]  n_st, n_oc;
    logic [31:0] n_oid;
    logic [4:0]  n_orun;
    logic        n_osw;

    logic [SW-1:0] scan_i;
    logic [2:0]    act;

    assign scan_i          = r_scan[SW-1:0];
    assign o_sts.scan_last = (r_scan == PW'(NT - 1));
    assign o_sts.req_type  = r_rt;
    assign act = (r_core_count == 3'd0) ? 3'd1 :
                 (r_core_count > 3'(NC)) ? 3'(NC) : r_core_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count  <= 3'd1;
            r_app_quantum <= 8'd3;
        end else if (i_cfg_wr) begin
            if (i_cfg_idx == rrts_pkg::CFG_CORE_COUNT) r_core_count <= i_cfg_data[2:0];
            else r_app_quantum <= i_cfg_data[7:0];
        end
    end

    // scan: first free slot, first slot matching kill id, least-loaded core
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rt  <= i_req_type;
            r_rc  <= i_core;
            r_drv <= i_is_driver;
            r_id  <= i_task_id;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
            r_free <= NIL;
            r_hit  <= NIL;
            r_best <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + 1'b1;
            if (r_free == NIL && !r_valid[scan_i]) r_free <= r_scan;
            if (r_hit == NIL && r_valid[scan_i] && r_tid[scan_i] == r_id)
                r_hit <= r_scan;
            if (r_scan < PW'(NC) && r_scan != '0 && 3'(r_scan) < act
                && r_cnt[r_scan[1:0]] < r_cnt[r_best])
                r_best <= r_scan[1:0];
        end
    end

    // tick decision
    logic [PW-1:0] t_r, t_nx, t_a;
    logic          t_keep, t_dec;
    always_comb begin
        t_r = r_run[r_rc];
        if (t_r >= NIL || !r_valid[t_r[SW-1:0]]) t_r = NIL;
        t_keep = (r_rc != 2'd0) && (r_cnt[r_rc] == 5'd1) && (t_r != NIL)
                 && (t_r == r_head[r_rc]);
        t_dec  = !t_keep && (t_r != NIL) && (r_qleft[t_r[SW-1:0]] != 8'd0);
        t_a    = (t_r != NIL) ? r_next[t_r[SW-1:0]] : r_head[r_rc];
        t_nx   = t_a;
        if (t_nx >= NIL || !r_valid[t_nx[SW-1:0]])
            t_nx = (r_rc != 2'd0) ? r_head[r_rc] : NIL;
        if (t_nx >= NIL || !r_valid[t_nx[SW-1:0]]) t_nx = NIL;
        if (t_keep || t_dec) t_nx = t_r;
    end

    logic [SW-1:0] fs, ks;
    logic [PW-1:0] kp, kn;
    logic [1:0]    kc;
    assign fs = r_free[SW-1:0];
    assign ks = r_hit[SW-1:0];
    assign kp = r_prev[ks];
    assign kn = r_next[ks];
    assign kc = r_score[ks];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= 32'd1;
            for (int c = 0; c < NC; c++) begin
                r_head[c] <= NIL;
                r_tail[c] <= NIL;
                r_run[c]  <= NIL;
                r_cnt[c]  <= '0;
            end
        end else begin
            if (i_cmd.do_add && r_free != NIL) begin
                r_valid[fs] <= 1'b1;
                r_tid[fs]   <= r_next_id;
                r_next_id   <= r_next_id + 32'd1;
                r_score[fs] <= r_best;
                r_qleft[fs] <= 8'd0;
                r_qtgt[fs]  <= r_drv ? 8'd0 : r_app_quantum;
                r_next[fs]  <= NIL;
                r_prev[fs]  <= r_tail[r_best];
                if (r_tail[r_best] != NIL) r_next[r_tail[r_best][SW-1:0]] <= r_free;
                else r_head[r_best] <= r_free;
                r_tail[r_best] <= r_free;
                r_cnt[r_best]  <= r_cnt[r_best] + 1'b1;
            end
            if (i_cmd.do_tick) begin
                if (t_dec) r_qleft[t_r[SW-1:0]] <= r_qleft[t_r[SW-1:0]] - 8'd1;
                else if (!t_keep && t_r != NIL)
                    r_qleft[t_r[SW-1:0]] <= r_qtgt[t_r[SW-1:0]];
                r_run[r_rc] <= t_nx;
            end
            if (i_cmd.do_kill && r_id != 32'd1 && r_hit != NIL) begin
                if (kp != NIL) r_next[kp[SW-1:0]] <= kn; else r_head[kc] <= kn;
                if (kn != NIL) r_prev[kn[SW-1:0]] <= kp; else r_tail[kc] <= kp;
                if (r_run[kc] == r_hit) r_run[kc] <= kp;
                if (r_cnt[kc] != '0) r_cnt[kc] <= r_cnt[kc] - 1'b1;
                r_valid[ks] <= 1'b0;
            end
        end
    end

    // result fields; all zero unless the request sets them
    always_comb begin
        n_st   = rrts_pkg::ST_OK;
        n_oid  = '0;
        n_oc   = '0;
        n_orun = '0;
        n_osw  = 1'b0;
        if (i_cmd.do_add) begin
            if (r_free == NIL) n_st = rrts_pkg::ST_FULL;
            else begin n_oid = r_next_id; n_oc = r_best; end
        end
        if (i_cmd.do_tick) begin
            n_oid  = (t_nx == NIL) ? 32'd0 : r_tid[t_nx[SW-1:0]];
            n_oc   = r_rc;
            n_orun = 5'(t_nx);
            n_osw  = !t_keep && !t_dec && (t_nx != t_r);
        end
        if (i_cmd.do_kill) begin
            if (r_id == 32'd1) n_st = rrts_pkg::ST_REFUSED;
            else if (r_hit == NIL) n_st = rrts_pkg::ST_NOTFOUND;
            else begin n_oid = r_id; n_oc = kc; end
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_add || i_cmd.do_tick || i_cmd.do_kill || i_cmd.load) begin
            r_st   <= n_st;
            r_oid  <= n_oid;
            r_oc   <= n_oc;
            r_orun <= n_orun;
            r_osw  <= n_osw;
        end
        if (i_cmd.emit) begin
            r_out_st   <= r_st;
            r_out_id   <= r_oid;
            r_out_core <= r_oc;
            r_out_run  <= r_orun;
            r_out_sw   <= r_osw;
        end
    end

    assign o_status       = r_out_st;
    assign o_result_id    = r_out_id;
    assign o_result_core  = r_out_core;
    assign o_running_slot = r_out_run;
    assign o_switched     = r_out_sw;

endmodule

@@ rtl/per_core_round_robin_task_scheduler.sv @@
// channel  | handshake                   | payload
// request  | i_valid / o_stall           | i_req_type i_core i_is_driver i_task_id
// result   | o_valid / i_stall           | o_status o_result_id o_result_core ...
// config   | i_cfg_valid / o_cfg_ready   | i_cfg_index i_cfg_data
// A request goes through accept, a scan of all 16 entries of the slot table
// (free slot, id match, core load), an update step and a result step.
// Reset clears slot valid bits, list heads and tails, counters, and sets the id counter to 1.
// A stalled result beat does not block the next request from being taken and
// scanned; its result waits after the update until the output register frees.
module per_core_round_robin_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_core,
    input  logic        i_is_driver,
    input  logic [31:0] i_task_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic [1:0]  o_result_core,
    output logic [4:0]  o_running_slot,
    output logic        o_switched,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rrts_pkg::t_cmd cmd;
    rrts_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_out_stall(i_stall), .o_out_valid(o_valid), .i_sts(sts), .o_cmd(cmd)
    );

    rrts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_wr(i_cfg_valid), .i_cfg_idx(i_cfg_index[0]), .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type), .i_core(i_core), .i_is_driver(i_is_driver),
        .i_task_id(i_task_id), .o_status(o_status), .o_result_id(o_result_id),
        .o_result_core(o_result_core), .o_running_slot(o_running_slot),
        .o_switched(o_switched)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.do_add, cmd.do_tick, cmd.do_kill, cmd.emit, cmd.load}))
        else $error("overlapping commands");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_stall) else $error("accept while busy");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid) else $error("result lost");

endmodule
